FILE: rtl/core/crcbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcbr_pkg
// Shared constants and helpers for the reflected-input CRC-16 unit.
// ----------------------------------------------------------------------------
package crcbr_pkg;

   localparam int unsigned CrcWidth  = 16;
   localparam int unsigned ByteWidth = 8;

   localparam logic [CrcWidth-1:0] CrcInit = 16'hFFFF;
   localparam logic [CrcWidth-1:0] CrcTop  = 16'h8000;
   localparam logic [CrcWidth-1:0] CrcPoly = 16'h1021;

   // reverse the bit order of one byte
   function automatic logic [ByteWidth-1:0] rev8(input logic [ByteWidth-1:0] v);
      logic [ByteWidth-1:0] r;
      for (int i = 0; i < ByteWidth; i++) begin
         r[i] = v[ByteWidth-1-i];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/crcbr_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcbr_fold
// Folds one reflected byte into the CRC register (poly 0x1021, msb first)
// and forms the per-byte reflected result word.
// ----------------------------------------------------------------------------
module crcbr_fold
   import crcbr_pkg::*;
(
   input  logic [CrcWidth-1:0]  crc_cur,
   input  logic [ByteWidth-1:0] data_byte,
   output logic [CrcWidth-1:0]  crc_next,
   output logic [CrcWidth-1:0]  crc_result
);

   // eight unrolled shift/xor steps
   always_comb begin
      logic [CrcWidth-1:0] c;
      c = crc_cur ^ {rev8(data_byte), {ByteWidth{1'b0}}};
      for (int i = 0; i < ByteWidth; i++) begin
         if ((c & CrcTop) != '0) begin
            c = {c[CrcWidth-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[CrcWidth-2:0], 1'b0};
         end
      end
      crc_next = c;
   end

   // each byte reflected in place, no byte swap
   assign crc_result = {rev8(crc_next[CrcWidth-1:ByteWidth]),
                        rev8(crc_next[ByteWidth-1:0])};

endmodule

FILE: rtl/core/crc16_ccitt_bit_reversed_bytes_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_ccitt_bit_reversed_bytes_unit
// CRC-16 (0x1021, init 0xFFFF) over reflected message bytes; one result per
// message with each result byte reflected in place.
//
//   channel  dir  tdata                 tlast
//   req      in   [7:0] data_byte       last_byte
//   rsp      out  [15:0] crc_value      -
//
// One byte per cycle unless a last byte waits on a stalled result; the
// 8-step fold is a single xor network between the input register and the
// crc/result registers. The last byte is registered in the input register,
// then in the result register, whose valid bit drives rsp_tvalid.
// Reset (synchronous) empties both stages and loads the crc with 0xFFFF.
// A stalled result holds the last byte of the next message in the input
// register; other bytes keep flowing while the result waits.
// ----------------------------------------------------------------------------
module crc16_ccitt_bit_reversed_bytes_unit
   import crcbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ByteWidth-1:0] req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,   // last_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CrcWidth-1:0]  rsp_tdata    // [15:0] crc_value
);

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;
   logic [CrcWidth-1:0]  crc_ff, crc_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CrcWidth-1:0]  out_crc_ff;
   logic [CrcWidth-1:0]  crc_next;
   logic [CrcWidth-1:0]  crc_result;
   logic                 out_free;
   logic                 advance;

   // fold network
   crcbr_fold u_fold (
      .crc_cur    (crc_ff),
      .data_byte  (in_byte_ff),
      .crc_next   (crc_next),
      .crc_result (crc_result)
   );

   // stage control
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_tready);

   always_comb begin
      crc_in = crc_ff;
      if (advance) begin
         crc_in = in_last_ff ? CrcInit : crc_next;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= CrcInit;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_crc_ff <= crc_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_crc_ff;

`ifndef SYNTH
   // crc starts each message from the init value
   a_reset_init: assert property (@(posedge clock) reset |=> crc_ff == CrcInit)
      else $error("crc not initialized after reset");

   a_last_reinit: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (crc_ff == CrcInit && rsp_tvalid))
      else $error("last byte did not produce result and reinit");

   // a blocked last byte must wait in the input register
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && out_valid_ff && !rsp_tready)
      |=> (in_valid_ff && $stable(crc_ff)))
      else $error("last byte lost while result stalled");
`endif

endmodule
